@@ rtl/shiprr_pkg.sv @@
// Shared constants for the signature-based RRIP replacement unit.
// Used by the top level; no dependencies.
package shiprr_pkg;

  // Request kinds carried on the mode field.
  localparam logic MODE_VICTIM = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Re-reference values.
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_NEAR    = 2'd0;

  // Hit counter limits.
  localparam logic [1:0] CNT_MAX  = 2'd3;
  localparam logic [1:0] CNT_ZERO = 2'd0;

  // Port widths fixed by the request format.
  localparam int SET_IN_W = 10;
  localparam int WAY_IN_W = 4;
  localparam int PC_W     = 48;

endpackage

@@ rtl/shiprr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; a read of the address being written returns the old data.
module shiprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/shiprr_cmod.sv @@
// Remainder by a constant modulus: a mask when the modulus is a power of two,
// otherwise a bit-serial restoring unit. No dependencies.
module shiprr_cmod #(
  parameter int IN_W    = 10,
  parameter int MODULUS = 1024,
  localparam int OUT_W  = (MODULUS > 1) ? $clog2(MODULUS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  value,
  output logic             busy,
  output logic [OUT_W-1:0] rem
);

  logic [OUT_W-1:0] rem_r;

  generate
    if ((MODULUS & (MODULUS - 1)) == 0) begin : g_mask
      // Power of two: the remainder is the low bits, ready the next cycle.
      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= OUT_W'(value & IN_W'(MODULUS - 1));
        end
      end
      assign busy = 1'b0;
    end else begin : g_serial
      localparam int CNT_W = $clog2(IN_W);
      logic             busy_r;
      logic [CNT_W-1:0] cnt_r;
      logic [IN_W-1:0]  bits_r;
      logic [OUT_W:0]   trial;

      // One restoring step: shift in the next bit, subtract once if needed.
      always_comb begin
        trial = {rem_r, bits_r[IN_W-1]};
        if (trial >= (OUT_W + 1)'(MODULUS)) begin
          trial = trial - (OUT_W + 1)'(MODULUS);
        end
      end

      // Step sequencer, one bit per cycle from the top.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
        end else if (start) begin
          busy_r <= 1'b1;
        end else if (busy_r && cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_r  <= '0;
          bits_r <= value;
          cnt_r  <= CNT_W'(IN_W - 1);
        end else if (busy_r) begin
          rem_r  <= trial[OUT_W-1:0];
          bits_r <= bits_r << 1;
          cnt_r  <= cnt_r - 1'b1;
        end
      end

      assign busy = busy_r;
    end
  endgenerate

  assign rem = rem_r;

endmodule

@@ rtl/ship_rrip_replacement_unit.sv @@
// Signature-based RRIP replacement unit. After reset a clearing pass over
// max(SETS, TABLE_ENTRIES) addresses initialises the set rows and the hit
// counter table; no request is taken meanwhile. Requests are then handled
// one at a time: each takes its remainders and reads its set row; a victim
// request then ages the row, writes it back and presents the chosen way, and
// an update does the counter table read-modify-write, a fill adding a final
// row write-back. A non-power-of-two SETS or TABLE_ENTRIES adds a bit-serial
// remainder step. Update requests produce no result.
module ship_rrip_replacement_unit #(
  parameter int SETS          = 1024,
  parameter int WAYS          = 16,
  parameter int TABLE_ENTRIES = 16384
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [shiprr_pkg::SET_IN_W-1:0] in_set_index,
  input  logic [shiprr_pkg::WAY_IN_W-1:0] in_way,
  input  logic [shiprr_pkg::PC_W-1:0]     in_pc,
  input  logic                            in_hit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [shiprr_pkg::WAY_IN_W-1:0] out_victim_way
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int SIG_W  = $clog2(TABLE_ENTRIES);
  localparam int LINE_W = SIG_W + 3;
  localparam int ROW_W  = WAYS * LINE_W;
  localparam int CLR_N  = (SETS > TABLE_ENTRIES) ? SETS : TABLE_ENTRIES;
  localparam int CLR_W  = $clog2(CLR_N);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_ROW   = 4'd3;
  localparam logic [3:0] S_VICT  = 4'd4;
  localparam logic [3:0] S_OUT   = 4'd5;
  localparam logic [3:0] S_CNT1  = 4'd6;
  localparam logic [3:0] S_CNT2  = 4'd7;

  typedef struct packed {
    logic [SIG_W-1:0] sig;
    logic             reused;
    logic [1:0]       rrpv;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  logic [3:0]       state_r, state_nxt;
  logic [CLR_W-1:0] clr_r;
  logic             mode_r, hit_r;
  logic [WAY_W-1:0] way_r;
  logic [SIG_W-1:0] old_sig_r;
  logic             fwd_r;
  logic [1:0]       fwd_val_r;
  row_t             row_r;
  logic [WAY_W-1:0] vic_r;
  logic             out_valid_r;
  logic [shiprr_pkg::WAY_IN_W-1:0] out_way_r;

  logic             accept;
  logic             set_busy, pc_busy;
  logic [SET_W-1:0] set_idx;
  logic [SIG_W-1:0] pc_sig;
  logic [6:0]       way_mod;
  logic             clr_rows, clr_cnts;

  logic [ROW_W-1:0] row_rdata, row_wdata;
  logic             row_we;
  logic [SET_W-1:0] row_waddr;
  row_t             row_rd, aged, upd_row;
  logic [1:0]       top, lift;
  logic [WAY_W-1:0] vic;

  logic             cnt_we;
  logic [SIG_W-1:0] cnt_waddr, cnt_raddr;
  logic [1:0]       cnt_wdata, cnt_rdata, cnt_new, cnt_after;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Way number wrapped into the configured associativity.
  always_comb begin
    way_mod = 7'(in_way);
    for (int i = 0; i < 8; i++) begin
      if (way_mod >= 7'(WAYS)) begin
        way_mod = way_mod - 7'(WAYS);
      end
    end
  end

  // Remainder units for the set number and the signature.
  shiprr_cmod #(.IN_W(shiprr_pkg::SET_IN_W), .MODULUS(SETS)) u_set_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (in_set_index),
    .busy  (set_busy),
    .rem   (set_idx)
  );

  shiprr_cmod #(.IN_W(shiprr_pkg::PC_W), .MODULUS(TABLE_ENTRIES)) u_pc_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (in_pc),
    .busy  (pc_busy),
    .rem   (pc_sig)
  );

  // Set rows and hit counter table.
  shiprr_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (set_idx),
    .rdata (row_rdata)
  );

  shiprr_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign row_rd = row_rdata;

  // Aging: lift every way by the amount that brings the largest value to 3.
  always_comb begin
    top[1] = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      top[1] = top[1] | row_rd[w].rrpv[1];
    end
    top[0] = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      top[0] = top[0] | (row_rd[w].rrpv[0] && (row_rd[w].rrpv[1] == top[1]));
    end
    lift = shiprr_pkg::RRPV_DISTANT - top;
    aged = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      aged[w].rrpv = row_rd[w].rrpv + lift;
    end
  end

  // First way of the aged row whose value is distant.
  always_comb begin
    vic = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_r[w].rrpv == shiprr_pkg::RRPV_DISTANT) begin
        vic = WAY_W'(w);
      end
    end
  end

  // Counter values seen by the fill path.
  assign cnt_new = fwd_r ? fwd_val_r : cnt_rdata;
  always_comb begin
    cnt_after = cnt_rdata;
    if (!row_r[way_r].reused && cnt_rdata != shiprr_pkg::CNT_ZERO) begin
      cnt_after = cnt_rdata - 2'd1;
    end
  end

  // Row written back on a hit or a fill.
  always_comb begin
    upd_row = row_r;
    if (state_r == S_CNT1) begin
      upd_row[way_r].reused = 1'b1;
      upd_row[way_r].rrpv   = shiprr_pkg::RRPV_NEAR;
    end else begin
      upd_row[way_r].reused = 1'b0;
      upd_row[way_r].sig    = pc_sig;
      upd_row[way_r].rrpv   = (cnt_new == shiprr_pkg::CNT_ZERO) ?
                              shiprr_pkg::RRPV_DISTANT : shiprr_pkg::RRPV_LONG;
    end
  end

  // Clearing pass coverage.
  assign clr_rows = ({1'b0, clr_r} < (CLR_W + 1)'(SETS));
  assign clr_cnts = ({1'b0, clr_r} < (CLR_W + 1)'(TABLE_ENTRIES));

  // Row memory write port.
  always_comb begin
    row_we    = 1'b0;
    row_waddr = set_idx;
    row_wdata = upd_row;
    unique case (state_r)
      S_CLEAR: begin
        row_we    = clr_rows;
        row_waddr = clr_r[SET_W-1:0];
        for (int w = 0; w < WAYS; w++) begin
          row_wdata[w*LINE_W +: LINE_W] = {{SIG_W{1'b0}}, 1'b0, shiprr_pkg::RRPV_DISTANT};
        end
      end
      S_VICT: begin
        row_we    = 1'b1;
        row_wdata = row_r;
      end
      S_CNT1:  row_we = hit_r;
      S_CNT2:  row_we = 1'b1;
      default: row_we = 1'b0;
    endcase
  end

  // Counter table ports.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = old_sig_r;
    cnt_wdata = cnt_after;
    cnt_raddr = pc_sig;
    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = clr_cnts;
        cnt_waddr = clr_r[SIG_W-1:0];
        cnt_wdata = shiprr_pkg::CNT_ZERO;
      end
      S_ROW:   cnt_raddr = row_rd[way_r].sig;
      S_CNT1: begin
        cnt_we = 1'b1;
        if (hit_r) begin
          cnt_wdata = (cnt_rdata == shiprr_pkg::CNT_MAX) ? shiprr_pkg::CNT_MAX :
                      cnt_rdata + 2'd1;
        end
      end
      default: cnt_we = 1'b0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == CLR_W'(CLR_N - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_MOD;
      S_MOD:   if (!set_busy && !pc_busy) state_nxt = S_ROW;
      S_ROW: begin
        state_nxt = (mode_r == shiprr_pkg::MODE_VICTIM) ? S_VICT : S_CNT1;
      end
      S_VICT:  state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      S_CNT1:  state_nxt = hit_r ? S_IDLE : S_CNT2;
      S_CNT2:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      hit_r  <= in_hit;
      way_r  <= WAY_W'(way_mod);
    end
    if (state_r == S_ROW) begin
      row_r     <= (mode_r == shiprr_pkg::MODE_VICTIM) ? aged : row_rd;
      old_sig_r <= row_rd[way_r].sig;
    end
    if (state_r == S_VICT) begin
      vic_r <= vic;
    end
    if (state_r == S_CNT1) begin
      fwd_r     <= (pc_sig == old_sig_r);
      fwd_val_r <= cnt_after;
    end
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_way_r <= shiprr_pkg::WAY_IN_W'(vic_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("request taken during clearing pass");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the result state");

  a_victim_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (mode_r == shiprr_pkg::MODE_VICTIM))
    else $error("result produced for an update request");

  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT2) |-> ($past(state_r) == S_CNT1 && !hit_r))
    else $error("fill write-back out of sequence");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the signature-based RRIP replacement unit.
// It depends on shiprr_pkg and ship_rrip_replacement_unit, and predicts each untyped victim.
module tb;
  import shiprr_pkg::*;

  localparam int SETS          = 1024;
  localparam int WAYS          = 16;
  localparam int TABLE_ENTRIES = 16384;
  localparam int LINES         = SETS * WAYS;
  localparam int SIG_W         = 14;
  localparam int ITEM_TARGET   = 1100;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int POOL_SETS     = 4;
  localparam int POOL_SIGS     = 8;
  localparam int PLAN_ROWS     = 14;

  // One row of the directed plan; typed rows carry a victim read off by hand.
  typedef struct {
    logic                mode;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way;
    logic [PC_W-1:0]     pc;
    logic                hit;
    bit                  typed;
    logic [WAY_IN_W-1:0] victim;
  } req_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_mode;
  logic [SET_IN_W-1:0] in_set_index;
  logic [WAY_IN_W-1:0] in_way;
  logic [PC_W-1:0]     in_pc;
  logic                in_hit;
  logic                out_valid;
  logic                out_stall;
  logic [WAY_IN_W-1:0] out_victim_way;

  // Shadow copy of the replacement state.
  logic [1:0]       line_rrpv   [LINES];
  bit               line_reused [LINES];
  logic [SIG_W-1:0] line_sig    [LINES];
  logic [1:0]       sig_ctr     [TABLE_ENTRIES];

  logic [WAY_IN_W-1:0] victim_q [$];
  req_row_t            plan [PLAN_ROWS];
  logic [SET_IN_W-1:0] pool_set [POOL_SETS];
  logic [SIG_W-1:0]    pool_sig [POOL_SIGS];

  int items_sent;
  int burst_left;
  int fail_count;
  int cycle_count;
  bit hold_req;

  ship_rrip_replacement_unit #(
    .SETS          (SETS),
    .WAYS          (WAYS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_set_index   (in_set_index),
    .in_way         (in_way),
    .in_pc          (in_pc),
    .in_hit         (in_hit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_victim_way (out_victim_way)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Age the set until some way is distant, then return the first distant way.
  function automatic logic [WAY_IN_W-1:0] age_and_pick(int base);
    logic [1:0]          top;
    logic [1:0]          lift;
    logic [WAY_IN_W-1:0] pick;
    bit                  found;
    top = RRPV_NEAR;
    for (int w = 0; w < WAYS; w++) begin
      if (line_rrpv[base + w] > top) top = line_rrpv[base + w];
    end
    lift = RRPV_DISTANT - top;
    for (int w = 0; w < WAYS; w++) begin
      line_rrpv[base + w] = line_rrpv[base + w] + lift;
    end
    pick = '0;
    found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_rrpv[base + w] == RRPV_DISTANT) begin
        pick = w[WAY_IN_W-1:0];
        found = 1'b1;
      end
    end
    return pick;
  endfunction

  // Train the signature counters on a hit or a fill and set the line's value.
  function automatic void train_line(int line, logic [PC_W-1:0] pc, logic was_hit);
    logic [SIG_W-1:0] old_sig;
    logic [SIG_W-1:0] new_sig;
    old_sig = line_sig[line];
    if (was_hit) begin
      line_reused[line] = 1'b1;
      if (sig_ctr[old_sig] != CNT_MAX) sig_ctr[old_sig] = sig_ctr[old_sig] + 2'd1;
      line_rrpv[line] = RRPV_NEAR;
    end else begin
      if (!line_reused[line] && sig_ctr[old_sig] != CNT_ZERO) begin
        sig_ctr[old_sig] = sig_ctr[old_sig] - 2'd1;
      end
      line_reused[line] = 1'b0;
      new_sig = pc[SIG_W-1:0];
      line_sig[line] = new_sig;
      line_rrpv[line] = (sig_ctr[new_sig] == CNT_ZERO) ? RRPV_DISTANT : RRPV_LONG;
    end
  endfunction

  function automatic logic [PC_W-1:0] rand_pc();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[PC_W-1:0];
  endfunction

  // A program counter whose signature comes from the small shared pool.
  function automatic logic [PC_W-1:0] pool_pc();
    logic [PC_W-1:0] raw;
    raw = rand_pc();
    return {raw[PC_W-1:SIG_W], pool_sig[$urandom_range(0, POOL_SIGS - 1)]};
  endfunction

  function automatic void refresh_pools();
    for (int i = 0; i < POOL_SETS; i++) pool_set[i] = $urandom_range(0, SETS - 1);
    for (int i = 0; i < POOL_SIGS; i++) pool_sig[i] = $urandom_range(0, TABLE_ENTRIES - 1);
  endfunction

  // Drop valid between bursts and choose the length of the next burst.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Offer one request, wait for it to be taken, then predict its effect.
  task automatic send_req(input logic mode, input logic [SET_IN_W-1:0] set_index,
                          input logic [WAY_IN_W-1:0] way, input logic [PC_W-1:0] pc,
                          input logic hit, input bit typed,
                          input logic [WAY_IN_W-1:0] typed_victim,
                          output logic [WAY_IN_W-1:0] predicted);
    int base;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_set_index <= set_index;
    in_way       <= way;
    in_pc        <= pc;
    in_hit       <= hit;
    do @(posedge clk); while (in_stall !== 1'b0);
    base = (int'(set_index) % SETS) * WAYS;
    if (mode == MODE_VICTIM) begin
      predicted = age_and_pick(base);
      victim_q.push_back(typed ? typed_victim : predicted);
    end else begin
      predicted = '0;
      train_line(base + (int'(way) % WAYS), pc, hit);
    end
    items_sent++;
    pace();
  endtask

  // Stop offering requests until every victim has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (victim_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Hold the result side off while a long run of victim requests backs up.
  task automatic pressure();
    logic [WAY_IN_W-1:0] v;
    hold_req = 1'b1;
    burst_left = 60;
    repeat (48) begin
      send_req(MODE_VICTIM, pool_set[$urandom_range(0, POOL_SETS - 1)], $urandom_range(0, 15),
               rand_pc(), $urandom_range(0, 1), 1'b0, '0, v);
    end
  endtask

  // Main stimulus: reset, directed plan, then random traffic.
  initial begin
    logic [WAY_IN_W-1:0] v;
    logic [SET_IN_W-1:0] s;
    int                  r;
    int                  next_drain;
    bit                  hold_done;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_VICTIM;
    in_set_index = '0;
    in_way       = '0;
    in_pc        = '0;
    in_hit       = 1'b0;
    hold_req     = 1'b0;
    items_sent   = 0;
    burst_left   = 0;
    fail_count   = 0;
    next_drain   = 300;
    hold_done    = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      line_rrpv[i]   = RRPV_DISTANT;
      line_reused[i] = 1'b0;
      line_sig[i]    = '0;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) sig_ctr[i] = CNT_ZERO;

    plan = '{
      // After reset every line is distant, so way 0 is chosen at both set extremes.
      '{MODE_VICTIM, 10'd0,    4'd0,  48'd0,             1'b0, 1'b1, 4'd0},
      '{MODE_VICTIM, 10'd1023, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 4'd0},
      // A fill of a never-reused line whose counter is already at zero.
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd0,             1'b0, 1'b0, 4'd0},
      // Repeated hits drive the counter up until it saturates.
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd0,             1'b1, 1'b0, 4'd0},
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd0,             1'b1, 1'b0, 4'd0},
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd0,             1'b1, 1'b0, 4'd0},
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd0,             1'b1, 1'b0, 4'd0},
      // Fills at the top way with the widest pc, and one that inserts long.
      '{MODE_UPDATE, 10'd0,    4'd15, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 4'd0},
      '{MODE_UPDATE, 10'd0,    4'd1,  48'h0000_0000_4000, 1'b0, 1'b0, 4'd0},
      '{MODE_VICTIM, 10'd0,    4'd0,  48'd0,             1'b0, 1'b0, 4'd0},
      '{MODE_UPDATE, 10'd1023, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0},
      // Refill of a reused line, then of one that was not reused.
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd5,             1'b0, 1'b0, 4'd0},
      '{MODE_UPDATE, 10'd0,    4'd0,  48'd7,             1'b0, 1'b0, 4'd0},
      '{MODE_VICTIM, 10'd1023, 4'd0,  48'd0,             1'b0, 1'b0, 4'd0}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_req(plan[i].mode, plan[i].set_index, plan[i].way, plan[i].pc, plan[i].hit,
               plan[i].typed, plan[i].victim, v);
    end
    drain();

    // Random traffic: mostly hit and miss sequences on a few hot sets, some noise.
    refresh_pools();
    while (items_sent < ITEM_TARGET) begin
      if (items_sent % 200 == 0) refresh_pools();
      if (!hold_done && items_sent >= 500) begin
        hold_done = 1'b1;
        pressure();
      end
      if (items_sent >= next_drain) begin
        next_drain += 350;
        drain();
      end
      r = $urandom_range(0, 99);
      s = pool_set[$urandom_range(0, POOL_SETS - 1)];
      if (r < 40) begin
        send_req(MODE_UPDATE, s, $urandom_range(0, 15), rand_pc(), 1'b1, 1'b0, '0, v);
      end else if (r < 75) begin
        // A miss: ask for a victim, then fill the way that will be chosen.
        send_req(MODE_VICTIM, s, $urandom_range(0, 15), rand_pc(), $urandom_range(0, 1),
                 1'b0, '0, v);
        send_req(MODE_UPDATE, s, v, pool_pc(), 1'b0, 1'b0, '0, v);
      end else if (r < 85) begin
        send_req(MODE_VICTIM, $urandom_range(0, SETS - 1), $urandom_range(0, 15), rand_pc(),
                 $urandom_range(0, 1), 1'b0, '0, v);
      end else begin
        send_req(MODE_UPDATE, $urandom_range(0, SETS - 1), $urandom_range(0, 15), rand_pc(),
                 $urandom_range(0, 1), 1'b0, '0, v);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (victim_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side stalls: changing patterns, plus a long hold-off on request.
  initial begin
    int hold_left;
    int phase_left;
    int stall_mode;
    int tick;
    out_stall  = 1'b0;
    hold_left  = 0;
    phase_left = 0;
    stall_mode = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= (tick % 7 < 3);
        endcase
      end
    end
  end

  // Compare each returned victim with the oldest prediction.
  always @(posedge clk) begin : result_check
    logic [WAY_IN_W-1:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (victim_q.size() == 0) begin
        $error("victim_way: no request waiting, expected none, actual %0d", out_victim_way);
        fail_count++;
      end else begin
        want = victim_q.pop_front();
        if (out_victim_way !== want) begin
          $error("victim_way: expected %0d, actual %0d", want, out_victim_way);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
